// ===== hw/rtl/bptc_pkg.sv =====
`timescale 1ns / 1ps

package bptc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SENS       = 3'd0;
    localparam logic [2:0] REG_OFFSET     = 3'd1;
    localparam logic [2:0] REG_SENS_TC    = 3'd2;
    localparam logic [2:0] REG_OFFSET_TC  = 3'd3;
    localparam logic [2:0] REG_REF_TEMP   = 3'd4;
    localparam logic [2:0] REG_TEMP_TC    = 3'd5;

    // Temperature thresholds, in hundredths of a degree
    localparam logic signed [19:0] TEMP_BASE  = 20'sd2000;
    // Offset from (temp1 - 2000) to (temp1 + 1500)
    localparam logic signed [19:0] COLD_DELTA = 20'sd3500;

    localparam logic signed [19:0] TEMP_MAX = 20'sd32767;
    localparam logic signed [19:0] TEMP_MIN = -20'sd32768;
    localparam logic [17:0]        PRESS_MAX = 18'h3ffff;

    typedef struct packed {
        logic [15:0] pressure_sensitivity;
        logic [15:0] pressure_offset;
        logic [15:0] sensitivity_temp_coef;
        logic [15:0] offset_temp_coef;
        logic [15:0] reference_temperature;
        logic [15:0] temp_coef_of_temp;
    } cal_t;

    // First-order results
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [18:0] dtemp;   // temp1 - 2000
        logic signed [19:0] temp1;
        logic signed [19:0] cold;    // temp1 + 1500
        logic signed [35:0] off1;
        logic signed [35:0] sens1;
        logic [16:0]        t2;      // dT^2 / 2^31
    } fo_t;

    // Second-order results
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [39:0] off;
        logic signed [39:0] sens;
        logic signed [15:0] temp;
    } so_t;

endpackage

// ===== hw/rtl/bptc_first_order.sv =====
`timescale 1ns / 1ps

module bptc_first_order
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [23:0]     d1,
    input  logic [23:0]     d2,
    input  bptc_pkg::cal_t  cal,
    output logic            out_valid,
    input  logic            out_ready,
    output bptc_pkg::fo_t   fo
);

    logic va_reg;
    logic vb_reg;
    logic vc_reg;
    logic en_a;
    logic en_b;
    logic en_c;

    logic [23:0]        d1_a_reg;
    logic signed [24:0] dt_a_reg;
    logic signed [24:0] dt_next;

    logic [23:0]        d1_b_reg;
    logic signed [41:0] p6_b_reg;
    logic signed [41:0] p4_b_reg;
    logic signed [41:0] p3_b_reg;
    logic signed [49:0] dd_b_reg;
    logic signed [41:0] p6_next;
    logic signed [41:0] p4_next;
    logic signed [41:0] p3_next;
    logic signed [49:0] dd_next;

    bptc_pkg::fo_t fo_c_reg;
    bptc_pkg::fo_t fo_next;

    assign en_c     = !vc_reg || out_ready;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    // Stage A: temperature difference from the reference
    always_comb
    begin
        dt_next = $signed({1'b0, d2}) - $signed({1'b0, cal.reference_temperature, 8'b0});
    end

    // Stage B: coefficient products and dT squared
    always_comb
    begin
        logic signed [16:0] c6;
        logic signed [16:0] c4;
        logic signed [16:0] c3;
        c6 = $signed({1'b0, cal.temp_coef_of_temp});
        c4 = $signed({1'b0, cal.offset_temp_coef});
        c3 = $signed({1'b0, cal.sensitivity_temp_coef});
        p6_next = dt_a_reg * c6;
        p4_next = dt_a_reg * c4;
        p3_next = dt_a_reg * c3;
        dd_next = dt_a_reg * dt_a_reg;
    end

    // Stage C: first-order temperature, offset and sensitivity
    always_comb
    begin
        logic signed [19:0] dtemp_x;
        logic signed [35:0] off_base;
        logic signed [35:0] off_corr;
        logic signed [35:0] sens_base;
        logic signed [35:0] sens_corr;
        dtemp_x   = $signed({p6_b_reg[41], p6_b_reg[41:23]});
        off_base  = $signed({4'b0, cal.pressure_offset, 16'b0});
        off_corr  = $signed({p4_b_reg[41], p4_b_reg[41:7]});
        sens_base = $signed({5'b0, cal.pressure_sensitivity, 15'b0});
        sens_corr = $signed({{2{p3_b_reg[41]}}, p3_b_reg[41:8]});
        fo_next.d1    = d1_b_reg;
        fo_next.dtemp = $signed(p6_b_reg[41:23]);
        fo_next.temp1 = dtemp_x + bptc_pkg::TEMP_BASE;
        fo_next.cold  = dtemp_x + bptc_pkg::COLD_DELTA;
        fo_next.off1  = off_base + off_corr;
        fo_next.sens1 = sens_base + sens_corr;
        fo_next.t2    = dd_b_reg[47:31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= in_valid;
            end
            if (en_b)
            begin
                vb_reg <= va_reg;
            end
            if (en_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            d1_a_reg <= d1;
            dt_a_reg <= dt_next;
        end
        if (en_b)
        begin
            d1_b_reg <= d1_a_reg;
            p6_b_reg <= p6_next;
            p4_b_reg <= p4_next;
            p3_b_reg <= p3_next;
            dd_b_reg <= dd_next;
        end
        if (en_c)
        begin
            fo_c_reg <= fo_next;
        end
    end

    assign out_valid = vc_reg;
    assign fo        = fo_c_reg;

endmodule

// ===== hw/rtl/bptc_second_order.sv =====
`timescale 1ns / 1ps

module bptc_second_order
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bptc_pkg::fo_t   fo,
    output logic            out_valid,
    input  logic            out_ready,
    output bptc_pkg::so_t   so
);

    logic vd_reg;
    logic ve_reg;
    logic en_d;
    logic en_e;

    bptc_pkg::fo_t fo_d_reg;
    logic [35:0]   d_sq_reg;
    logic [35:0]   e_sq_reg;
    logic          lo_d_reg;
    logic          vlo_d_reg;
    logic [35:0]   d_sq_next;
    logic [35:0]   e_sq_next;

    bptc_pkg::so_t so_e_reg;
    bptc_pkg::so_t so_next;

    assign en_e     = !ve_reg || out_ready;
    assign en_d     = !vd_reg || en_e;
    assign in_ready = en_d;

    // Stage D: squares of the distances below the two thresholds
    always_comb
    begin
        logic signed [37:0] sq_a;
        logic signed [39:0] sq_b;
        sq_a      = fo.dtemp * fo.dtemp;
        sq_b      = fo.cold * fo.cold;
        d_sq_next = sq_a[35:0];
        e_sq_next = sq_b[35:0];
    end

    // Stage E: apply the cold corrections, saturate temperature
    always_comb
    begin
        logic [38:0]        five_d;
        logic [38:0]        seven_e;
        logic [39:0]        eleven_e;
        logic signed [39:0] off_x;
        logic signed [39:0] sens_x;
        logic signed [39:0] off_d;
        logic signed [39:0] off_e;
        logic signed [39:0] sens_d;
        logic signed [39:0] sens_e;
        logic signed [19:0] t2_x;
        logic signed [19:0] temp_full;
        five_d   = {1'b0, d_sq_reg, 2'b0} + {3'b0, d_sq_reg};
        seven_e  = {e_sq_reg, 3'b0} - {3'b0, e_sq_reg};
        eleven_e = {1'b0, e_sq_reg, 3'b0} + {3'b0, e_sq_reg, 1'b0} + {4'b0, e_sq_reg};
        off_x    = $signed({{4{fo_d_reg.off1[35]}}, fo_d_reg.off1});
        sens_x   = $signed({{4{fo_d_reg.sens1[35]}}, fo_d_reg.sens1});
        off_d    = lo_d_reg  ? $signed({2'b0, five_d[38:1]})   : '0;
        sens_d   = lo_d_reg  ? $signed({3'b0, five_d[38:2]})   : '0;
        off_e    = vlo_d_reg ? $signed({1'b0, seven_e})        : '0;
        sens_e   = vlo_d_reg ? $signed({1'b0, eleven_e[39:1]}) : '0;
        t2_x     = lo_d_reg  ? $signed({3'b0, fo_d_reg.t2})    : '0;
        temp_full = fo_d_reg.temp1 - t2_x;

        so_next.d1   = fo_d_reg.d1;
        so_next.off  = off_x - off_d - off_e;
        so_next.sens = sens_x - sens_d - sens_e;
        if (temp_full > bptc_pkg::TEMP_MAX)
        begin
            so_next.temp = bptc_pkg::TEMP_MAX[15:0];
        end
        else if (temp_full < bptc_pkg::TEMP_MIN)
        begin
            so_next.temp = bptc_pkg::TEMP_MIN[15:0];
        end
        else
        begin
            so_next.temp = temp_full[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            if (en_d)
            begin
                vd_reg <= in_valid;
            end
            if (en_e)
            begin
                ve_reg <= vd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            fo_d_reg  <= fo;
            d_sq_reg  <= d_sq_next;
            e_sq_reg  <= e_sq_next;
            lo_d_reg  <= fo.dtemp[18];
            vlo_d_reg <= fo.cold[19];
        end
        if (en_e)
        begin
            so_e_reg <= so_next;
        end
    end

    assign out_valid = ve_reg;
    assign so        = so_e_reg;

    // The very-cold correction only ever comes with the cold one
    a_cold_nested: assert property (@(posedge clk) disable iff (!rst_n)
        vd_reg && vlo_d_reg |-> lo_d_reg)
        else $error("very-cold flag without cold flag");

endmodule

// ===== hw/rtl/bptc_pressure.sv =====
`timescale 1ns / 1ps

module bptc_pressure
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bptc_pkg::so_t      so,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [17:0]        pressure,
    output logic signed [15:0] temperature
);

    logic vf_reg;
    logic vg_reg;
    logic vh_reg;
    logic en_f;
    logic en_g;
    logic en_h;

    logic [43:0]        pl_f_reg;
    logic signed [44:0] ph_f_reg;
    logic signed [39:0] off_f_reg;
    logic signed [15:0] temp_f_reg;
    logic [43:0]        pl_next;
    logic signed [44:0] ph_next;

    logic signed [63:0] full_g_reg;
    logic signed [39:0] off_g_reg;
    logic signed [15:0] temp_g_reg;
    logic signed [63:0] full_next;

    logic [17:0]        press_h_reg;
    logic signed [15:0] temp_h_reg;
    logic [17:0]        press_next;

    assign en_h     = !vh_reg || out_ready;
    assign en_g     = !vg_reg || en_h;
    assign en_f     = !vf_reg || en_g;
    assign in_ready = en_f;

    // Stage F: D1 times the sensitivity, split in two partial products
    always_comb
    begin
        logic signed [24:0] d1_s;
        logic signed [19:0] sens_hi;
        d1_s    = $signed({1'b0, so.d1});
        sens_hi = $signed(so.sens[39:20]);
        pl_next = {20'b0, so.d1} * {24'b0, so.sens[19:0]};
        ph_next = d1_s * sens_hi;
    end

    // Stage G: merge the partial products
    always_comb
    begin
        logic signed [63:0] ph_x;
        ph_x      = $signed({{19{ph_f_reg[44]}}, ph_f_reg});
        full_next = (ph_x <<< 20) + $signed({20'b0, pl_f_reg});
    end

    // Stage H: remove the offset, scale and clamp
    always_comb
    begin
        logic signed [43:0] scaled;
        logic signed [43:0] off_x;
        logic signed [43:0] diff;
        scaled = $signed({full_g_reg[63], full_g_reg[63:21]});
        off_x  = $signed({{4{off_g_reg[39]}}, off_g_reg});
        diff   = scaled - off_x;
        if (diff[43])
        begin
            press_next = '0;
        end
        else if (|diff[42:33])
        begin
            press_next = bptc_pkg::PRESS_MAX;
        end
        else
        begin
            press_next = diff[32:15];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
        end
        else
        begin
            if (en_f)
            begin
                vf_reg <= in_valid;
            end
            if (en_g)
            begin
                vg_reg <= vf_reg;
            end
            if (en_h)
            begin
                vh_reg <= vg_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            pl_f_reg   <= pl_next;
            ph_f_reg   <= ph_next;
            off_f_reg  <= so.off;
            temp_f_reg <= so.temp;
        end
        if (en_g)
        begin
            full_g_reg <= full_next;
            off_g_reg  <= off_f_reg;
            temp_g_reg <= temp_f_reg;
        end
        if (en_h)
        begin
            press_h_reg <= press_next;
            temp_h_reg  <= temp_g_reg;
        end
    end

    assign out_valid   = vh_reg;
    assign pressure    = press_h_reg;
    assign temperature = temp_h_reg;

endmodule

// ===== hw/rtl/baro_pressure_temp_compensation_core.sv =====
`timescale 1ns / 1ps

// Barometric sensor compensation: raw D1/D2 conversions in, pressure in Pa
// and temperature in 0.01 C out, second-order scheme with cold corrections.
//
// Request channel: in_valid / in_stall carrying raw_pressure and
// raw_temperature. Result channel: out_valid / out_stall carrying
// pressure_pa and temperature_centi. A request moves on a rising edge with
// valid high and stall low. Every request yields exactly one result.
//
// Calibration words C1..C6 are loaded through cfg_write / cfg_index /
// cfg_data; the user loads them only while the pipeline is empty, which
// the block does not enforce. An index above five is dropped.
// Throughput: one request per cycle while out_stall stays low. The result
// reaches out_valid through the eight-stage multiplier chain (dT, coefficient
// products, first-order sums, squares, corrections, split D1*SENS partial
// products, their merge, offset removal and clamp).
//
// Reset clears all stage valid bits and the calibration words to zero.
// When the receiver stalls, the output register holds its result; empty
// stages behind it keep filling, and in_stall rises only once every stage
// up to the input holds a request.
module baro_pressure_temp_compensation_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [23:0]        raw_pressure,
    input  logic [23:0]        raw_temperature,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [17:0]        pressure_pa,
    output logic signed [15:0] temperature_centi
);

    bptc_pkg::cal_t cal_reg;

    logic          fo_ready;
    logic          fo_valid;
    bptc_pkg::fo_t fo;
    logic          so_ready;
    logic          so_valid;
    bptc_pkg::so_t so;
    logic          pr_ready;

    // Calibration words; hold until rewritten
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bptc_pkg::REG_SENS:      cal_reg.pressure_sensitivity  <= cfg_data;
                bptc_pkg::REG_OFFSET:    cal_reg.pressure_offset       <= cfg_data;
                bptc_pkg::REG_SENS_TC:   cal_reg.sensitivity_temp_coef <= cfg_data;
                bptc_pkg::REG_OFFSET_TC: cal_reg.offset_temp_coef      <= cfg_data;
                bptc_pkg::REG_REF_TEMP:  cal_reg.reference_temperature <= cfg_data;
                bptc_pkg::REG_TEMP_TC:   cal_reg.temp_coef_of_temp     <= cfg_data;
                default:                 cal_reg <= cal_reg;
            endcase
        end
    end

    // First order: dT, coefficient products, TEMP/OFF/SENS
    bptc_first_order u_first
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (fo_ready),
        .d1        (raw_pressure),
        .d2        (raw_temperature),
        .cal       (cal_reg),
        .out_valid (fo_valid),
        .out_ready (so_ready),
        .fo        (fo)
    );

    // Second order: cold and very-cold corrections, temperature clamp
    bptc_second_order u_second
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fo_valid),
        .in_ready  (so_ready),
        .fo        (fo),
        .out_valid (so_valid),
        .out_ready (pr_ready),
        .so        (so)
    );

    // Pressure: split D1*SENS multiply, offset removal, clamp, output register
    bptc_pressure u_press
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (so_valid),
        .in_ready    (pr_ready),
        .so          (so),
        .out_valid   (out_valid),
        .out_ready   (!out_stall),
        .pressure    (pressure_pa),
        .temperature (temperature_centi)
    );

    assign in_stall = !fo_ready;

    // Back-pressure reaches the input only from a held result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output not held");

    // The pipeline comes out of reset empty
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid on leaving reset");

endmodule
